@@ sv/bwu_pkg.sv @@
package bwu_pkg;

  localparam int COORD_BITS = 14;
  localparam int PIX_BITS   = 12;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 24;

  localparam int DW  = ((COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS + 1) + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int MW  = CW;
  localparam int QW  = OUT_BITS - 1;
  localparam int NW  = MW + FRAC_BITS;
  localparam int XW  = NW + MW;
  localparam int NST = QW + 6;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic signed [OUT_BITS-1:0] NEG_ONE = (FRAC_BITS >= OUT_BITS - 1) ? OUT_MIN :
                                                   OUT_BITS'(-(64'sd1 <<< FRAC_BITS));

  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cross_t;
  typedef logic [MW-1:0] mag_t;
  typedef logic [QW-1:0] quo_t;

  typedef struct packed {
    mag_t rem_u;
    mag_t rem_v;
    quo_t q_u;
    quo_t q_v;
    quo_t low_u;
    quo_t low_v;
    mag_t den;
    logic neg_u;
    logic neg_v;
    logic ovf_u;
    logic ovf_v;
    logic deg;
  } div_t;

endpackage

@@ sv/barycentric_weight_unit.sv @@
// Barycentric weight unit: takes three screen vertices and a pixel, forms the
// edge cross products u, v and the doubled area w, and returns u/w and v/w as
// signed fixed point (16 fraction bits, truncated toward zero, saturated to
// 24 bits). A zero-area triangle raises degenerate with weight_u at -1.0 and
// weight_v at zero. The pipeline accepts one item per clock while in_stall is
// low. It registers the edge vectors, products and cross products, then the
// magnitudes, the overflow check with divider seed, each restoring divider
// step (one quotient bit per stage, both weights in parallel) and the output
// register. Stalled stages hold while empty stages behind them keep filling.
module barycentric_weight_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] in_vertex_a_x,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] in_vertex_a_y,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] in_vertex_b_x,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] in_vertex_b_y,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] in_vertex_c_x,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] in_vertex_c_y,
  input  logic [bwu_pkg::PIX_BITS-1:0]          in_pixel_x,
  input  logic [bwu_pkg::PIX_BITS-1:0]          in_pixel_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bwu_pkg::OUT_BITS-1:0]   out_weight_u,
  output logic signed [bwu_pkg::OUT_BITS-1:0]   out_weight_v,
  output logic                                  out_degenerate
);

  localparam int NST = bwu_pkg::NST;
  localparam int QW  = bwu_pkg::QW;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  bwu_pkg::cross_t u, v, w;

  bwu_cross u_cross (
    .clk (clk),
    .en  (en[2:0]),
    .ax  (in_vertex_a_x),
    .ay  (in_vertex_a_y),
    .bx  (in_vertex_b_x),
    .by  (in_vertex_b_y),
    .cx  (in_vertex_c_x),
    .cy  (in_vertex_c_y),
    .px  (in_pixel_x),
    .py  (in_pixel_y),
    .u_r (u),
    .v_r (v),
    .w_r (w)
  );

  // magnitudes and signs
  bwu_pkg::mag_t mu_r, mv_r, mw_r;
  logic          negu_r, negv_r, deg3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mu_r   <= u[bwu_pkg::CW-1] ? bwu_pkg::MW'(~u + 1'b1) : bwu_pkg::MW'(u);
      mv_r   <= v[bwu_pkg::CW-1] ? bwu_pkg::MW'(~v + 1'b1) : bwu_pkg::MW'(v);
      mw_r   <= w[bwu_pkg::CW-1] ? bwu_pkg::MW'(~w + 1'b1) : bwu_pkg::MW'(w);
      negu_r <= u[bwu_pkg::CW-1] != w[bwu_pkg::CW-1];
      negv_r <= v[bwu_pkg::CW-1] != w[bwu_pkg::CW-1];
      deg3_r <= w == '0;
    end
  end

  // overflow check and divider seed
  logic [bwu_pkg::XW-1:0] nxu, nxv, r0u, r0v, dx;
  bwu_pkg::div_t          seed;
  bwu_pkg::div_t          div_r [QW+1];

  always_comb begin
    nxu  = {{bwu_pkg::MW{1'b0}}, mu_r, {bwu_pkg::FRAC_BITS{1'b0}}};
    nxv  = {{bwu_pkg::MW{1'b0}}, mv_r, {bwu_pkg::FRAC_BITS{1'b0}}};
    r0u  = nxu >> QW;
    r0v  = nxv >> QW;
    dx   = {{(bwu_pkg::XW-bwu_pkg::MW){1'b0}}, mw_r};
    seed.rem_u = r0u[bwu_pkg::MW-1:0];
    seed.rem_v = r0v[bwu_pkg::MW-1:0];
    seed.q_u   = '0;
    seed.q_v   = '0;
    seed.low_u = nxu[QW-1:0];
    seed.low_v = nxv[QW-1:0];
    seed.den   = mw_r;
    seed.neg_u = negu_r;
    seed.neg_v = negv_r;
    seed.ovf_u = r0u >= dx;
    seed.ovf_v = r0v >= dx;
    seed.deg   = deg3_r;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      div_r[0] <= seed;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    bwu_div_step u_step (
      .clk  (clk),
      .en   (en[5+i]),
      .d_in (div_r[i]),
      .d_r  (div_r[i+1])
    );
  end

  // sign, saturation and degenerate case
  bwu_pkg::div_t                       fin;
  logic signed [bwu_pkg::OUT_BITS-1:0] wu_nxt, wv_nxt;

  always_comb begin
    fin = div_r[QW];
    if (fin.deg) begin
      wu_nxt = bwu_pkg::NEG_ONE;
      wv_nxt = '0;
    end else begin
      if (fin.ovf_u) begin
        wu_nxt = fin.neg_u ? bwu_pkg::OUT_MIN : bwu_pkg::OUT_MAX;
      end else begin
        wu_nxt = fin.neg_u ? -$signed({1'b0, fin.q_u}) : $signed({1'b0, fin.q_u});
      end
      if (fin.ovf_v) begin
        wv_nxt = fin.neg_v ? bwu_pkg::OUT_MIN : bwu_pkg::OUT_MAX;
      end else begin
        wv_nxt = fin.neg_v ? -$signed({1'b0, fin.q_v}) : $signed({1'b0, fin.q_v});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_weight_u   <= wu_nxt;
      out_weight_v   <= wv_nxt;
      out_degenerate <= fin.deg;
    end
  end

  a_deg_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_weight_u == bwu_pkg::NEG_ONE && out_weight_v == '0)
    else $error("degenerate result with wrong weights");

  a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !en[0] |=> v_r[0])
    else $error("blocked first stage lost its item");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted transfer not captured");

  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-2] && !v_r[NST-1] |=> out_valid)
    else $error("result did not reach the output register");

endmodule

@@ sv/bwu_cross.sv @@
module bwu_cross (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] ax,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] ay,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] bx,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] by,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] cx,
  input  logic signed [bwu_pkg::COORD_BITS-1:0] cy,
  input  logic [bwu_pkg::PIX_BITS-1:0]      px,
  input  logic [bwu_pkg::PIX_BITS-1:0]      py,
  output bwu_pkg::cross_t                   u_r,
  output bwu_pkg::cross_t                   v_r,
  output bwu_pkg::cross_t                   w_r
);

  bwu_pkg::diff_t e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  bwu_pkg::prod_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;

  // edge vectors
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1x_r <= bwu_pkg::DW'(bx) - bwu_pkg::DW'(ax);
      e1y_r <= bwu_pkg::DW'(cx) - bwu_pkg::DW'(ax);
      e1z_r <= bwu_pkg::DW'(ax) - $signed(bwu_pkg::DW'(px));
      e2x_r <= bwu_pkg::DW'(by) - bwu_pkg::DW'(ay);
      e2y_r <= bwu_pkg::DW'(cy) - bwu_pkg::DW'(ay);
      e2z_r <= bwu_pkg::DW'(ay) - $signed(bwu_pkg::DW'(py));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p0_r <= bwu_pkg::PW'(e1y_r) * bwu_pkg::PW'(e2z_r);
      p1_r <= bwu_pkg::PW'(e1z_r) * bwu_pkg::PW'(e2y_r);
      p2_r <= bwu_pkg::PW'(e1z_r) * bwu_pkg::PW'(e2x_r);
      p3_r <= bwu_pkg::PW'(e1x_r) * bwu_pkg::PW'(e2z_r);
      p4_r <= bwu_pkg::PW'(e1x_r) * bwu_pkg::PW'(e2y_r);
      p5_r <= bwu_pkg::PW'(e1y_r) * bwu_pkg::PW'(e2x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      u_r <= bwu_pkg::CW'(p0_r) - bwu_pkg::CW'(p1_r);
      v_r <= bwu_pkg::CW'(p2_r) - bwu_pkg::CW'(p3_r);
      w_r <= bwu_pkg::CW'(p4_r) - bwu_pkg::CW'(p5_r);
    end
  end

endmodule

@@ sv/bwu_div_step.sv @@
module bwu_div_step (
  input  logic          clk,
  input  logic          en,
  input  bwu_pkg::div_t d_in,
  output bwu_pkg::div_t d_r
);

  logic [bwu_pkg::MW:0] tu, tv, du, dv;
  logic                 geu, gev;
  bwu_pkg::div_t        d_nxt;

  always_comb begin
    tu  = {d_in.rem_u, d_in.low_u[bwu_pkg::QW-1]};
    tv  = {d_in.rem_v, d_in.low_v[bwu_pkg::QW-1]};
    du  = tu - {1'b0, d_in.den};
    dv  = tv - {1'b0, d_in.den};
    geu = tu >= {1'b0, d_in.den};
    gev = tv >= {1'b0, d_in.den};
    d_nxt       = d_in;
    d_nxt.rem_u = geu ? du[bwu_pkg::MW-1:0] : tu[bwu_pkg::MW-1:0];
    d_nxt.rem_v = gev ? dv[bwu_pkg::MW-1:0] : tv[bwu_pkg::MW-1:0];
    d_nxt.q_u   = {d_in.q_u[bwu_pkg::QW-2:0], geu};
    d_nxt.q_v   = {d_in.q_v[bwu_pkg::QW-2:0], gev};
    d_nxt.low_u = {d_in.low_u[bwu_pkg::QW-2:0], 1'b0};
    d_nxt.low_v = {d_in.low_v[bwu_pkg::QW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule
